FILE: src/mf2f_pkg.sv
// shared constants and types for the minifloat to binary32 decoder
package mf2f_pkg;

    localparam int WORD_W = 16;
    localparam int SINGLE_W = 32;
    localparam int CLASS_W = 2;
    localparam int FRAC_CFG_W = 4;
    localparam int EXP_CFG_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [FRAC_CFG_W-1:0] FRAC_MIN = 4'd2;
    localparam logic [FRAC_CFG_W-1:0] FRAC_MAX = 4'd10;
    localparam logic [EXP_CFG_W-1:0] EXP_MIN = 3'd3;
    localparam logic [EXP_CFG_W-1:0] EXP_MAX = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT_WIDTH = 1'd1;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_FINITE = 2'd0,
        CLASS_INF = 2'd1,
        CLASS_NAN = 2'd2
    } value_class_t;

endpackage

FILE: src/minifloat_to_float32_decoder_unit.sv
// minifloat to ieee binary32 decoder, one word per cycle while out is not stalled
//
//   channel  | handshake              | payload
//   in       | in_valid / in_stall    | encoded_word
//   out      | out_valid / out_stall  | single_bits, value_class
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a word accepted sits in the input register, reaches the result register when
// that advances, and is offered on out from then on; one word per cycle unless stalled
// the result register advances whenever it is empty or being taken
// reset: no word in flight, fraction width 10, exponent width 5
// a stall on the output holds the result and, once the input register is full,
// stalls the input the same cycle
module minifloat_to_float32_decoder_unit
    import mf2f_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [WORD_W-1:0]     encoded_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SINGLE_W-1:0]   single_bits,
    output logic [CLASS_W-1:0]    value_class
);

    logic [FRAC_CFG_W-1:0] frac_w_reg;
    logic [EXP_CFG_W-1:0]  exp_w_reg;
    logic                  in_valid_reg;
    logic [WORD_W-1:0]     word_reg;
    logic                  out_valid_reg;
    logic [SINGLE_W-1:0]   bits_reg;
    logic [SINGLE_W-1:0]   bits_next;
    value_class_t          class_reg;
    value_class_t          class_next;

    logic                  adv;
    logic                  in_take;
    logic [3:0]            f;
    logic [2:0]            e;
    logic [9:0]            frac;
    logic [4:0]            expf;
    logic                  sign;
    logic [4:0]            all_ones;
    logic [4:0]            bias;
    logic [3:0]            p;
    logic [22:0]           mant;
    logic [7:0]            ex;
    logic [WORD_W-1:0]     w_shift;

    assign cfg_ready = 1'b1;

    // stage 1 moves when stage 2 can take its word
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !adv;
    assign in_take  = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign single_bits = bits_reg;
    assign value_class = class_reg;

    always_comb
    begin
        f = (frac_w_reg < FRAC_MIN) ? FRAC_MIN :
            (frac_w_reg > FRAC_MAX) ? FRAC_MAX : frac_w_reg;
        e = (exp_w_reg < EXP_MIN) ? EXP_MIN :
            (exp_w_reg > EXP_MAX) ? EXP_MAX : exp_w_reg;
        frac = word_reg[9:0] & ((10'd1 << f) - 10'd1);
        w_shift = word_reg >> f;
        all_ones = (5'd1 << e) - 5'd1;
        expf = w_shift[4:0] & all_ones;
        sign = w_shift[e];
        bias = (5'd1 << (e - 3'd1)) - 5'd1;
        p = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (frac[i])
            begin
                p = 4'(i);
            end
        end
        mant = 23'd0;
        ex = 8'd0;
        class_next = CLASS_FINITE;
        if (expf == all_ones)
        begin
            if (frac == 10'd0)
            begin
                bits_next = {sign, 31'h7F800000};
                class_next = CLASS_INF;
            end
            else
            begin
                bits_next = 32'h7FC00000;
                class_next = CLASS_NAN;
            end
        end
        else if (expf == 5'd0)
        begin
            if (frac == 10'd0)
            begin
                bits_next = {sign, 31'd0};
            end
            else
            begin
                // subnormal: normalize on the leading one
                ex = 8'd128 + 8'(p) - 8'(bias) - 8'(f);
                mant = {13'd0, frac ^ (10'd1 << p)} << (5'd23 - 5'(p));
                bits_next = {sign, ex, mant};
            end
        end
        else
        begin
            ex = 8'd127 + 8'(expf) - 8'(bias);
            mant = {13'd0, frac} << (5'd23 - 5'(f));
            bits_next = {sign, ex, mant};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_w_reg    <= FRAC_MAX;
            exp_w_reg     <= EXP_MAX;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRACTION_WIDTH: frac_w_reg <= cfg_data[FRAC_CFG_W-1:0];
                    REG_EXPONENT_WIDTH: exp_w_reg <= cfg_data[EXP_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (adv)
            begin
                in_valid_reg  <= in_take;
                out_valid_reg <= in_valid_reg;
            end
            else if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg <= encoded_word;
        end
        if (adv && in_valid_reg)
        begin
            bits_reg  <= bits_next;
            class_reg <= class_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(single_bits))
        else $error("result changed under stall");
    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_class == CLASS_NAN |-> single_bits == 32'h7FC00000)
        else $error("nan pattern wrong");
    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_class == CLASS_INF |-> single_bits[30:0] == 31'h7F800000)
        else $error("infinity pattern wrong");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule
